FILE: rtl/pool_transfer_kahan_accumulator_top_macros.svh
// Assertion macros for the pool transfer accumulator checker.
// Both macros are clocked on the rising edge and disabled while reset is low.
`ifndef POOL_TRANSFER_KAHAN_ACCUMULATOR_TOP_MACROS_SVH
`define POOL_TRANSFER_KAHAN_ACCUMULATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTKA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptka assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTKA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptka assertion failed");

`endif

FILE: rtl/ptka_pkg.sv
// Package for the pool transfer accumulator: codes, enums and structs.
// Used by every RTL module of the block except the interfaces; depends on nothing.
`timescale 1ns / 1ps

package ptka_pkg;

    localparam int unsigned POOLS_DEF = 256;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned OPW       = 3;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_XFER = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_SAME = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;

    localparam logic [63:0] QNAN_DEFAULT = 64'hFFF8_0000_0000_0000;
    localparam logic [10:0] EXP_MAX      = 11'h7FF;

    typedef enum logic [2:0] {
        OP_LOAD, OP_REJECT, OP_XFER, OP_SKIP, OP_READ, OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        STEP_Y, STEP_T, STEP_D, STEP_C, STEP_P
    } t_step;

    typedef enum logic [2:0] {
        BK_CLEAR, BK_IDLE, BK_LOAD, BK_RDWAIT, BK_ISSUE, BK_WAIT, BK_DONE
    } t_bk_state;

    typedef enum logic [2:0] {
        FA_IDLE, FA_ALIGN, FA_ADD, FA_NORM, FA_ROUND, FA_DONE
    } t_fa_state;

    typedef struct packed {
        logic        start;
        logic        sub;
        logic [63:0] a;
        logic [63:0] b;
    } t_fa_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_fa_rsp;

endpackage

FILE: rtl/ptka_ifs.sv
// Valid/ready channel interfaces of the pool transfer accumulator.
// Input items, result items and the mode register write channel.
`timescale 1ns / 1ps

interface ptka_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  source_pool;
    logic [7:0]  sink_pool;
    logic [63:0] amount;
    modport source(output valid, cmd, source_pool, sink_pool, amount, input ready);
    modport sink(input valid, cmd, source_pool, sink_pool, amount, output ready);
endinterface

interface ptka_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] pool_balance;
    logic [1:0]  status;
    modport source(output valid, pool_balance, status, input ready);
    modport sink(input valid, pool_balance, status, output ready);
endinterface

interface ptka_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

FILE: rtl/pool_transfer_kahan_accumulator_top.sv
// A transfer runs two pool updates on one shared iterative double adder, one add a pool
// plain and four adds a pool compensated. Items run one at a time; the next is taken from
// the queue no earlier than the cycle after the result beat is taken.
// Reset (synchronous, active low) clears the mode and zeroes the correction memory, one entry
// a cycle.
`timescale 1ns / 1ps

module pool_transfer_kahan_accumulator_top #(
    parameter int unsigned POOLS = ptka_pkg::POOLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptka_in_if.sink     i_in,
    ptka_out_if.source  o_out,
    ptka_cfg_if.sink    i_cfg
);
    // The clearing pass after reset zeroes one correction entry a cycle. Up to
    // two input beats are taken into the queue meanwhile and wait there until it ends. No
    // beat is taken on any channel while reset is held.
    localparam int unsigned IW = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int unsigned W  = ptka_pkg::OPW + 2 * IW + 64;

    // Mode register: one beat on the configuration channel writes it.
    logic r_comp_mode;

    // Front to queue and queue to back.
    logic         w_push;
    logic [W-1:0] w_push_data;
    logic         w_full;
    logic         w_q_valid;
    logic [W-1:0] w_q_data;
    logic         w_pop;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            r_comp_mode <= i_cfg.data;
        end
    end

    // The front wraps indexes and sorts each item into a small operation code,
    // so the back only sees work it must do and statuses it must report.
    // While reset is held the front sees a full queue and takes nothing.
    ptka_front #(.POOLS(POOLS)) u_front (
        .i_in   (i_in),
        .i_full (w_full || !i_rst_n),
        .o_push (w_push),
        .o_data (w_push_data)
    );

    // The queue lets input beats be taken while the back is busy or its result
    // still waits to be taken.
    ptka_fifo #(.W(W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // The back finishes all memory writes of an item before it takes the next,
    // so consecutive items on the same pool always see updated entries.
    ptka_back #(.POOLS(POOLS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_comp_mode),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_pop),
        .o_out     (o_out)
    );
endmodule

FILE: rtl/ptka_fifo.sv
// Short queue between the front and back of the accumulator.
// Depth from ptka_pkg; payload width is a parameter.
`timescale 1ns / 1ps

module ptka_fifo #(
    parameter int unsigned W = 80
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int unsigned PW = (ptka_pkg::Q_DEPTH > 1) ? $clog2(ptka_pkg::Q_DEPTH) : 1;
    localparam int unsigned CW = $clog2(ptka_pkg::Q_DEPTH + 1);

    logic [W-1:0]  r_mem [ptka_pkg::Q_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(ptka_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(ptka_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(ptka_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

FILE: rtl/ptka_front.sv
// Front end: accepts input beats, wraps pool indexes and classifies items.
// Depends on ptka_pkg and ptka_ifs; feeds ptka_fifo.
`timescale 1ns / 1ps

module ptka_front #(
    parameter int unsigned POOLS = ptka_pkg::POOLS_DEF
) (
    ptka_in_if.sink i_in,
    input  logic    i_full,
    output logic    o_push,
    output logic [ptka_pkg::OPW + 2 * ((POOLS > 1) ? $clog2(POOLS) : 1) + 63:0] o_data
);
    localparam int unsigned IW = (POOLS > 1) ? $clog2(POOLS) : 1;

    logic [IW-1:0]      w_mod_tab [256];
    logic [IW-1:0]      w_src;
    logic [IW-1:0]      w_dst;
    logic               w_nan;
    logic               w_neg;
    ptka_pkg::t_op      w_op;

    // Index wrap table, built at elaboration.
    for (genvar g = 0; g < 256; g++) begin : g_tab
        assign w_mod_tab[g] = IW'(g % POOLS);
    end

    assign w_src = w_mod_tab[i_in.source_pool];
    assign w_dst = w_mod_tab[i_in.sink_pool];

    // Below zero: sign set, not a zero and not a NaN.
    assign w_nan = (&i_in.amount[62:52]) && (|i_in.amount[51:0]);
    assign w_neg = i_in.amount[63] && (|i_in.amount[62:0]) && !w_nan;

    always_comb begin
        case (i_in.cmd)
            ptka_pkg::CMD_LOAD: w_op = w_neg ? ptka_pkg::OP_REJECT : ptka_pkg::OP_LOAD;
            ptka_pkg::CMD_XFER: w_op = (w_src == w_dst) ? ptka_pkg::OP_SKIP : ptka_pkg::OP_XFER;
            ptka_pkg::CMD_READ: w_op = ptka_pkg::OP_READ;
            default:            w_op = ptka_pkg::OP_NOP;
        endcase
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign o_data     = {w_op, w_src, w_dst, i_in.amount};
endmodule

FILE: rtl/ptka_fadd.sv
// Iterative IEEE-754 double adder with round to nearest even.
// Depends on ptka_pkg; one add or subtract per request.
`timescale 1ns / 1ps

module ptka_fadd (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptka_pkg::t_fa_req i_req,
    output ptka_pkg::t_fa_rsp o_rsp
);
    ptka_pkg::t_fa_state r_state, n_state;
    logic        r_sa, n_sa;
    logic        r_sb, n_sb;
    logic        r_zsign, n_zsign;
    logic [10:0] r_ea, n_ea;
    logic [10:0] r_eb, n_eb;
    logic [55:0] r_ma, n_ma;
    logic [55:0] r_mb, n_mb;
    logic [56:0] r_m, n_m;
    logic [11:0] r_e, n_e;
    logic [63:0] r_res, n_res;

    logic [63:0] w_be;
    logic        w_a_nan, w_b_nan, w_a_inf, w_b_inf;
    logic        w_swap;
    logic [63:0] w_x, w_y;
    logic [10:0] w_d;
    logic [55:0] w_mask, w_shr;
    logic        w_sticky;
    logic [56:0] w_sum;
    logic        w_up;
    logic [53:0] w_mt;
    logic [52:0] w_mant;
    logic [11:0] w_e_rnd;

    assign w_be    = {i_req.b[63] ^ i_req.sub, i_req.b[62:0]};
    assign w_a_nan = (&i_req.a[62:52]) && (|i_req.a[51:0]);
    assign w_b_nan = (&i_req.b[62:52]) && (|i_req.b[51:0]);
    assign w_a_inf = (&i_req.a[62:52]) && !(|i_req.a[51:0]);
    assign w_b_inf = (&i_req.b[62:52]) && !(|i_req.b[51:0]);
    assign w_swap  = w_be[62:0] > i_req.a[62:0];
    assign w_x     = w_swap ? w_be : i_req.a;
    assign w_y     = w_swap ? i_req.a : w_be;

    assign w_d      = r_ea - r_eb;
    assign w_mask   = ~({56{1'b1}} << w_d[5:0]);
    assign w_shr    = r_mb >> w_d[5:0];
    assign w_sticky = |(r_mb & w_mask);

    assign w_sum = (r_sa == r_sb) ? ({1'b0, r_ma} + {1'b0, r_mb})
                                  : ({1'b0, r_ma} - {1'b0, r_mb});

    assign w_up    = r_m[2] && (r_m[1] || r_m[0] || r_m[3]);
    assign w_mt    = {1'b0, r_m[55:3]} + {53'd0, w_up};
    assign w_mant  = w_mt[53] ? w_mt[53:1] : w_mt[52:0];
    assign w_e_rnd = w_mt[53] ? r_e + 12'd1 : r_e;

    always_comb begin
        n_state = r_state;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_zsign = r_zsign;
        n_ea    = r_ea;
        n_eb    = r_eb;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_m     = r_m;
        n_e     = r_e;
        n_res   = r_res;
        case (r_state)
            ptka_pkg::FA_IDLE: begin
                if (i_req.start) begin
                    n_state = ptka_pkg::FA_DONE;
                    // A NaN operand is passed on quieted, the first one first.
                    if (w_a_nan) begin
                        n_res = i_req.a | (64'd1 << 51);
                    end else if (w_b_nan) begin
                        n_res = i_req.b | (64'd1 << 51);
                    end else if (w_a_inf && w_b_inf && (i_req.a[63] != w_be[63])) begin
                        n_res = ptka_pkg::QNAN_DEFAULT;
                    end else if (w_a_inf) begin
                        n_res = i_req.a;
                    end else if (w_b_inf) begin
                        n_res = w_be;
                    end else begin
                        n_state = ptka_pkg::FA_ALIGN;
                        n_sa    = w_x[63];
                        n_sb    = w_y[63];
                        n_zsign = i_req.a[63] && w_be[63];
                        n_ea    = (w_x[62:52] == '0) ? 11'd1 : w_x[62:52];
                        n_eb    = (w_y[62:52] == '0) ? 11'd1 : w_y[62:52];
                        n_ma    = {(w_x[62:52] != '0), w_x[51:0], 3'b000};
                        n_mb    = {(w_y[62:52] != '0), w_y[51:0], 3'b000};
                    end
                end
            end
            ptka_pkg::FA_ALIGN: begin
                if (w_d >= 11'd56) begin
                    n_mb = {55'd0, |r_mb};
                end else begin
                    n_mb = {w_shr[55:1], w_shr[0] | w_sticky};
                end
                n_state = ptka_pkg::FA_ADD;
            end
            ptka_pkg::FA_ADD: begin
                n_m     = w_sum;
                n_e     = {1'b0, r_ea};
                n_state = ptka_pkg::FA_NORM;
            end
            ptka_pkg::FA_NORM: begin
                if (r_m == '0) begin
                    n_res   = {r_zsign, 63'd0};
                    n_state = ptka_pkg::FA_DONE;
                end else if (r_m[56]) begin
                    n_m     = {1'b0, r_m[56:2], r_m[1] | r_m[0]};
                    n_e     = r_e + 12'd1;
                    n_state = ptka_pkg::FA_ROUND;
                end else if (!r_m[55] && (r_e > 12'd1)) begin
                    // Coarse steps of eight while the top byte is empty.
                    if ((r_m[55:48] == '0) && (r_e > 12'd8)) begin
                        n_m = {r_m[48:0], 8'd0};
                        n_e = r_e - 12'd8;
                    end else begin
                        n_m = {r_m[55:0], 1'b0};
                        n_e = r_e - 12'd1;
                    end
                end else begin
                    n_state = ptka_pkg::FA_ROUND;
                end
            end
            ptka_pkg::FA_ROUND: begin
                if (w_e_rnd >= {1'b0, ptka_pkg::EXP_MAX}) begin
                    n_res = {r_sa, ptka_pkg::EXP_MAX, 52'd0};
                end else begin
                    n_res = {r_sa, w_mant[52] ? w_e_rnd[10:0] : 11'd0, w_mant[51:0]};
                end
                n_state = ptka_pkg::FA_DONE;
            end
            ptka_pkg::FA_DONE: begin
                n_state = ptka_pkg::FA_IDLE;
            end
            default: begin
                n_state = ptka_pkg::FA_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptka_pkg::FA_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa    <= n_sa;
        r_sb    <= n_sb;
        r_zsign <= n_zsign;
        r_ea    <= n_ea;
        r_eb    <= n_eb;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_m     <= n_m;
        r_e     <= n_e;
        r_res   <= n_res;
    end

    assign o_rsp.done = (r_state == ptka_pkg::FA_DONE);
    assign o_rsp.res  = r_res;
endmodule

FILE: rtl/ptka_back.sv
// Back end: balance and correction memories, the sequencer that runs the
// additions of one item, and the output register. Uses ptka_fadd and ptka_pkg.
`timescale 1ns / 1ps

module ptka_back #(
    parameter int unsigned POOLS = ptka_pkg::POOLS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_mode,
    input  logic       i_q_valid,
    input  logic [ptka_pkg::OPW + 2 * ((POOLS > 1) ? $clog2(POOLS) : 1) + 63:0] i_q_data,
    output logic       o_q_pop,
    ptka_out_if.source o_out
);
    localparam int unsigned IW = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int unsigned W  = ptka_pkg::OPW + 2 * IW + 64;

    ptka_pkg::t_bk_state r_state, n_state;
    ptka_pkg::t_op       r_op, n_op;
    ptka_pkg::t_step     r_step, n_step;
    logic [IW-1:0] r_clr_cnt, n_clr_cnt;
    logic [IW-1:0] r_addr, n_addr;
    logic [IW-1:0] r_dst, n_dst;
    logic [63:0]   r_amt, n_amt;
    logic          r_leg, n_leg;
    logic [63:0]   r_y, n_y;
    logic [63:0]   r_t, n_t;
    logic [63:0]   r_d, n_d;
    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_out_bal, n_out_bal;
    logic [1:0]    r_out_st, n_out_st;
    logic [63:0]   r_bal_q, r_cor_q;

    logic [63:0] bal_mem [POOLS];
    logic [63:0] cor_mem [POOLS];

    logic          w_bal_we, w_cor_we;
    logic [63:0]   w_bal_wd, w_cor_wd;
    logic [IW-1:0] w_cor_wa;
    logic [63:0]   w_delta;
    ptka_pkg::t_step   w_first;
    ptka_pkg::t_fa_req w_fa_req;
    ptka_pkg::t_fa_rsp w_fa_rsp;

    ptka_fadd u_fadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_fa_req),
        .o_rsp   (w_fa_rsp)
    );

    assign w_delta = r_leg ? r_amt : {~r_amt[63], r_amt[62:0]};
    assign w_first = i_mode ? ptka_pkg::STEP_Y : ptka_pkg::STEP_P;

    // Operands of the adder for each step of the compensated or plain update.
    always_comb begin
        w_fa_req.start = (r_state == ptka_pkg::BK_ISSUE);
        case (r_step)
            ptka_pkg::STEP_Y: begin
                w_fa_req.a = w_delta; w_fa_req.b = r_cor_q; w_fa_req.sub = 1'b1;
            end
            ptka_pkg::STEP_T: begin
                w_fa_req.a = r_bal_q; w_fa_req.b = r_y; w_fa_req.sub = 1'b0;
            end
            ptka_pkg::STEP_D: begin
                w_fa_req.a = r_t; w_fa_req.b = r_bal_q; w_fa_req.sub = 1'b1;
            end
            ptka_pkg::STEP_C: begin
                w_fa_req.a = r_d; w_fa_req.b = r_y; w_fa_req.sub = 1'b1;
            end
            default: begin
                w_fa_req.a = r_bal_q; w_fa_req.b = r_amt; w_fa_req.sub = !r_leg;
            end
        endcase
    end

    always_comb begin
        logic v_leg_end;
        v_leg_end   = 1'b0;
        n_state     = r_state;
        n_op        = r_op;
        n_step      = r_step;
        n_clr_cnt   = r_clr_cnt;
        n_addr      = r_addr;
        n_dst       = r_dst;
        n_amt       = r_amt;
        n_leg       = r_leg;
        n_y         = r_y;
        n_t         = r_t;
        n_d         = r_d;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_bal   = r_out_bal;
        n_out_st    = r_out_st;
        w_bal_we    = 1'b0;
        w_bal_wd    = r_amt;
        w_cor_we    = 1'b0;
        w_cor_wa    = r_addr;
        w_cor_wd    = '0;
        o_q_pop     = 1'b0;
        case (r_state)
            ptka_pkg::BK_CLEAR: begin
                w_cor_we = 1'b1;
                w_cor_wa = r_clr_cnt;
                if (r_clr_cnt == IW'(POOLS - 1)) begin
                    n_state = ptka_pkg::BK_IDLE;
                end else begin
                    n_clr_cnt = r_clr_cnt + 1'b1;
                end
            end
            ptka_pkg::BK_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_op    = ptka_pkg::t_op'(i_q_data[W-1 -: ptka_pkg::OPW]);
                    n_addr  = i_q_data[64 + IW +: IW];
                    n_dst   = i_q_data[64 +: IW];
                    n_amt   = i_q_data[63:0];
                    n_leg   = 1'b0;
                    n_step  = w_first;
                    case (ptka_pkg::t_op'(i_q_data[W-1 -: ptka_pkg::OPW]))
                        ptka_pkg::OP_LOAD: n_state = ptka_pkg::BK_LOAD;
                        ptka_pkg::OP_READ,
                        ptka_pkg::OP_XFER: n_state = ptka_pkg::BK_RDWAIT;
                        default:           n_state = ptka_pkg::BK_DONE;
                    endcase
                end
            end
            ptka_pkg::BK_LOAD: begin
                w_bal_we = 1'b1;
                w_cor_we = 1'b1;
                n_state  = ptka_pkg::BK_DONE;
            end
            ptka_pkg::BK_RDWAIT: begin
                n_state = (r_op == ptka_pkg::OP_XFER) ? ptka_pkg::BK_ISSUE : ptka_pkg::BK_DONE;
            end
            ptka_pkg::BK_ISSUE: begin
                n_state = ptka_pkg::BK_WAIT;
            end
            ptka_pkg::BK_WAIT: begin
                if (w_fa_rsp.done) begin
                    case (r_step)
                        ptka_pkg::STEP_Y: begin
                            n_y = w_fa_rsp.res; n_step = ptka_pkg::STEP_T;
                            n_state = ptka_pkg::BK_ISSUE;
                        end
                        ptka_pkg::STEP_T: begin
                            n_t = w_fa_rsp.res; n_step = ptka_pkg::STEP_D;
                            n_state = ptka_pkg::BK_ISSUE;
                        end
                        ptka_pkg::STEP_D: begin
                            n_d = w_fa_rsp.res; n_step = ptka_pkg::STEP_C;
                            n_state = ptka_pkg::BK_ISSUE;
                        end
                        ptka_pkg::STEP_C: begin
                            w_bal_we  = 1'b1;
                            w_bal_wd  = r_t;
                            w_cor_we  = 1'b1;
                            w_cor_wd  = w_fa_rsp.res;
                            v_leg_end = 1'b1;
                        end
                        default: begin
                            w_bal_we  = 1'b1;
                            w_bal_wd  = w_fa_rsp.res;
                            v_leg_end = 1'b1;
                        end
                    endcase
                    if (v_leg_end) begin
                        if (!r_leg) begin
                            n_leg   = 1'b1;
                            n_addr  = r_dst;
                            n_step  = w_first;
                            n_state = ptka_pkg::BK_RDWAIT;
                        end else begin
                            n_state = ptka_pkg::BK_DONE;
                        end
                    end
                end
            end
            ptka_pkg::BK_DONE: begin
                n_out_valid = 1'b1;
                n_out_bal   = (r_op == ptka_pkg::OP_READ) ? r_bal_q : '0;
                case (r_op)
                    ptka_pkg::OP_REJECT: n_out_st = ptka_pkg::ST_NEG;
                    ptka_pkg::OP_SKIP:   n_out_st = ptka_pkg::ST_SAME;
                    default:             n_out_st = ptka_pkg::ST_DONE;
                endcase
                n_state = ptka_pkg::BK_IDLE;
            end
            default: begin
                n_state = ptka_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_bal_we) begin
            bal_mem[r_addr] <= w_bal_wd;
        end
        if (w_cor_we) begin
            cor_mem[w_cor_wa] <= w_cor_wd;
        end
        r_bal_q <= bal_mem[r_addr];
        r_cor_q <= cor_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptka_pkg::BK_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_step    <= n_step;
        r_addr    <= n_addr;
        r_dst     <= n_dst;
        r_amt     <= n_amt;
        r_leg     <= n_leg;
        r_y       <= n_y;
        r_t       <= n_t;
        r_d       <= n_d;
        r_out_bal <= n_out_bal;
        r_out_st  <= n_out_st;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pool_balance = r_out_bal;
    assign o_out.status       = r_out_st;
endmodule

FILE: rtl/ptka_checker.sv
// Port-level checks of the pool transfer accumulator, bound to the top level.
// Depends on ptka_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pool_transfer_kahan_accumulator_top_macros.svh"

module ptka_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_bal,
    input logic [1:0]  i_out_status
);
    // A stalled result beat holds.
    `PTKA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_bal) && $stable(i_out_status))
    // Only defined status codes are reported.
    `PTKA_ASSERT_NOW(a_status_code, i_clk, i_rst_n, i_out_valid, (i_out_status == ptka_pkg::ST_DONE) || (i_out_status == ptka_pkg::ST_SAME) || (i_out_status == ptka_pkg::ST_NEG))
    // Skipped and rejected items carry a zero balance.
    `PTKA_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_out_valid && (i_out_status != ptka_pkg::ST_DONE), i_out_bal == '0)
endmodule

bind pool_transfer_kahan_accumulator_top ptka_checker u_ptka_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_bal    (o_out.pool_balance),
    .i_out_status (o_out.status)
);
